// ===== hw/rtl/c8eu_pkg.sv =====
// c8eu_pkg: types and constants shared by the 8-bit execute unit.
// No dependencies.
package c8eu_pkg;

	typedef struct packed {
		logic [5:0]  op;
		logic [7:0]  operand;
		logic [7:0]  operand_high;
		logic [15:0] address;
		logic [15:0] return_address;
	} in_item_t;

	typedef struct packed {
		logic        write_enable;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic        jump_enable;
		logic [15:0] jump_target;
		logic [7:0]  acc_out;
		logic [7:0]  x_out;
		logic [7:0]  y_out;
		logic [7:0]  sp_out;
		logic [7:0]  flags_out;
		logic        last;
	} out_item_t;

	localparam logic [5:0] OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2;
	localparam logic [5:0] OP_STA = 6'd3,  OP_STX = 6'd4,  OP_STY = 6'd5;
	localparam logic [5:0] OP_TAX = 6'd6,  OP_TAY = 6'd7,  OP_TXA = 6'd8;
	localparam logic [5:0] OP_TYA = 6'd9,  OP_TSX = 6'd10, OP_TXS = 6'd11;
	localparam logic [5:0] OP_PHA = 6'd12, OP_PHP = 6'd13, OP_PLA = 6'd14;
	localparam logic [5:0] OP_PLP = 6'd15, OP_AND = 6'd16, OP_EOR = 6'd17;
	localparam logic [5:0] OP_ORA = 6'd18, OP_BIT = 6'd19, OP_ADC = 6'd20;
	localparam logic [5:0] OP_SBC = 6'd21, OP_CMP = 6'd22, OP_CPX = 6'd23;
	localparam logic [5:0] OP_CPY = 6'd24, OP_INC = 6'd25, OP_INX = 6'd26;
	localparam logic [5:0] OP_INY = 6'd27, OP_DEC = 6'd28, OP_DEX = 6'd29;
	localparam logic [5:0] OP_DEY = 6'd30, OP_ASLA = 6'd31, OP_ASLM = 6'd32;
	localparam logic [5:0] OP_LSRA = 6'd33, OP_LSRM = 6'd34, OP_ROLA = 6'd35;
	localparam logic [5:0] OP_ROLM = 6'd36, OP_RORA = 6'd37, OP_RORM = 6'd38;
	localparam logic [5:0] OP_JMP = 6'd39, OP_JSR = 6'd40, OP_RTS = 6'd41;
	localparam logic [5:0] OP_NOP = 6'd42;

	localparam logic [7:0] STACK_PAGE = 8'h01;
	localparam logic [7:0] SP_RESET   = 8'hFD;
	localparam logic [7:0] FLAGS_RESET = 8'h24;

endpackage

// ===== hw/rtl/c8eu_front.sv =====
// c8eu_front: input register; takes requests and holds one for the back end.
// Depends on c8eu_pkg.
module c8eu_front import c8eu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t din,
	output logic     valid,
	output in_item_t item,
	input  logic     take
);

	logic     valid_q;
	in_item_t item_q;

	assign full  = valid_q && !take;
	assign valid = valid_q;
	assign item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (push && !full) valid_q <= 1'b1;
			else if (take) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) item_q <= din;
	end

endmodule

// ===== hw/rtl/c8eu_back.sv =====
// c8eu_back: architectural registers and ALU; emits results to an output register.
// Depends on c8eu_pkg.
module c8eu_back import c8eu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid,
	input  in_item_t  item,
	output logic      take,
	output logic      empty,
	input  logic      pop,
	output out_item_t dout
);

	logic [7:0] a_q, x_q, y_q, sp_q, p_q;
	logic       jsr_q;      // second JSR result still owed
	logic       out_v_q;
	out_item_t  out_q;
	logic [15:0] jsr_addr_q;
	logic [7:0]  jsr_lo_q;

	logic        room, fire;
	logic [7:0]  na, nx, ny, nsp, np, r, v;
	logic [8:0]  sum;
	logic        wr, jp;
	logic [15:0] wa, jt;
	logic [7:0]  wd;
	logic [7:0]  mi;

	assign room  = !out_v_q || pop;
	assign fire  = valid && room && !jsr_q;
	assign take  = fire;
	assign empty = !out_v_q;
	assign dout  = out_q;

	always_comb begin
		na = a_q; nx = x_q; ny = y_q; nsp = sp_q; np = p_q;
		wr = 1'b0; wa = '0; wd = '0; jp = 1'b0; jt = '0;
		r = '0; v = '0; sum = '0;
		mi = (item.op == OP_SBC) ? ~item.operand : item.operand;
		case (item.op)
			OP_LDA, OP_PLA: begin r = item.operand; na = r; end
			OP_LDX: begin r = item.operand; nx = r; end
			OP_LDY: begin r = item.operand; ny = r; end
			OP_TAX: begin r = a_q; nx = r; end
			OP_TAY: begin r = a_q; ny = r; end
			OP_TXA: begin r = x_q; na = r; end
			OP_TYA: begin r = y_q; na = r; end
			OP_TSX: begin r = sp_q; nx = r; end
			OP_AND: begin r = a_q & item.operand; na = r; end
			OP_EOR: begin r = a_q ^ item.operand; na = r; end
			OP_ORA: begin r = a_q | item.operand; na = r; end
			OP_ADC, OP_SBC: begin
				sum = {1'b0, a_q} + {1'b0, mi} + {8'd0, p_q[0]};
				r = sum[7:0]; na = r; np[0] = sum[8];
				np[6] = ~(a_q[7] ^ mi[7]) & (a_q[7] ^ r[7]);
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				v = (item.op == OP_CMP) ? a_q : (item.op == OP_CPX) ? x_q : y_q;
				sum = {1'b0, v} - {1'b0, item.operand};
				r = sum[7:0]; np[0] = !sum[8];
			end
			OP_INC: r = item.operand + 8'd1;
			OP_DEC: r = item.operand - 8'd1;
			OP_INX: begin r = x_q + 8'd1; nx = r; end
			OP_INY: begin r = y_q + 8'd1; ny = r; end
			OP_DEX: begin r = x_q - 8'd1; nx = r; end
			OP_DEY: begin r = y_q - 8'd1; ny = r; end
			OP_ASLA, OP_ASLM, OP_LSRA, OP_LSRM,
			OP_ROLA, OP_ROLM, OP_RORA, OP_RORM: begin
				v = item.op[0] ? a_q : item.operand;
				if (item.op == OP_ASLA || item.op == OP_ASLM ||
				    item.op == OP_ROLA || item.op == OP_ROLM) begin
					np[0] = v[7];
					r = {v[6:0], (item.op == OP_ROLA || item.op == OP_ROLM) & p_q[0]};
				end else begin
					np[0] = v[0];
					r = {(item.op == OP_RORA || item.op == OP_RORM) & p_q[0], v[7:1]};
				end
				if (item.op[0]) na = r;
			end
			default: ;
		endcase
		// N and Z from the result for every operation that loads or computes a value
		case (item.op)
			OP_LDA, OP_LDX, OP_LDY, OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TSX,
			OP_PLA, OP_AND, OP_EOR, OP_ORA, OP_ADC, OP_SBC, OP_CMP, OP_CPX,
			OP_CPY, OP_INC, OP_DEC, OP_INX, OP_INY, OP_DEX, OP_DEY,
			OP_ASLA, OP_ASLM, OP_LSRA, OP_LSRM, OP_ROLA, OP_ROLM,
			OP_RORA, OP_RORM: begin
				np[7] = r[7]; np[1] = (r == 8'd0);
			end
			default: ;
		endcase
		case (item.op)
			OP_STA: begin wr = 1'b1; wa = item.address; wd = a_q; end
			OP_STX: begin wr = 1'b1; wa = item.address; wd = x_q; end
			OP_STY: begin wr = 1'b1; wa = item.address; wd = y_q; end
			OP_TXS: nsp = x_q;
			OP_PHA, OP_PHP: begin
				wr = 1'b1; wa = {STACK_PAGE, sp_q};
				wd = (item.op == OP_PHA) ? a_q : (p_q | 8'h30);
				nsp = sp_q - 8'd1;
			end
			OP_PLA: nsp = sp_q + 8'd1;
			OP_PLP: begin nsp = sp_q + 8'd1; np = (item.operand & 8'hCF) | 8'h20; end
			OP_BIT: begin
				np[7] = item.operand[7]; np[6] = item.operand[6];
				np[1] = ((a_q & item.operand) == 8'd0);
			end
			OP_INC, OP_DEC, OP_ASLM, OP_LSRM, OP_ROLM, OP_RORM: begin
				wr = 1'b1; wa = item.address; wd = r;
			end
			OP_JMP: begin jp = 1'b1; jt = item.address; end
			OP_JSR: begin
				wr = 1'b1; wa = {STACK_PAGE, sp_q};
				wd = item.return_address[15:8]; nsp = sp_q - 8'd2;
			end
			OP_RTS: begin
				nsp = sp_q + 8'd2; jp = 1'b1;
				jt = {item.operand_high, item.operand} + 16'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0; x_q <= '0; y_q <= '0;
			sp_q <= SP_RESET; p_q <= FLAGS_RESET;
			jsr_q <= 1'b0; out_v_q <= 1'b0;
		end else begin
			if (fire) begin
				a_q <= na; x_q <= nx; y_q <= ny; sp_q <= nsp; p_q <= np;
				jsr_q <= (item.op == OP_JSR);
				out_v_q <= 1'b1;
			end else if (jsr_q && room) begin
				jsr_q <= 1'b0;
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= '{write_enable: wr, write_address: wa, write_data: wd,
				jump_enable: jp, jump_target: jt, acc_out: na, x_out: nx,
				y_out: ny, sp_out: nsp, flags_out: np,
				last: (item.op != OP_JSR)};
			jsr_addr_q <= item.address;
			jsr_lo_q   <= item.return_address[7:0];
		end else if (jsr_q && room) begin
			out_q.write_address <= {STACK_PAGE, sp_q + 8'd1};
			out_q.write_data    <= jsr_lo_q;
			out_q.jump_enable   <= 1'b1;
			out_q.jump_target   <= jsr_addr_q;
			out_q.last          <= 1'b1;
		end
	end

	a_jsr_second: assert property (@(posedge clk) disable iff (!arst_n)
		jsr_q && room |=> out_v_q && out_q.last && out_q.jump_enable)
		else $error("JSR second result missing");
	a_no_fire_jsr: assert property (@(posedge clk) disable iff (!arst_n)
		jsr_q |-> !fire) else $error("item taken during JSR");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !pop |=> out_v_q && $stable(out_q))
		else $error("result changed while waiting");

endmodule

// ===== hw/rtl/cpu_8bit_execute_unit_top.sv =====
// cpu_8bit_execute_unit_top: 6502-style execute stage, top level.
// Depends on c8eu_pkg, c8eu_front, c8eu_back.
//
// Usage:
//  - Requests enter on din with push; one is accepted when push is high and
//    full is low. Each carries a decoded operation and its operand bytes.
//  - Results leave on dout; a result waits while empty is low and is taken
//    with pop. JSR yields two results (high then low return byte push); all
//    other operations yield one, flagged by last.
//  - A request is accepted into the input register, then moves into the result
//    register when the back end takes it; a stall can hold it in between.
//  - Throughput: one request per cycle while results are popped and no JSR is
//    pending; JSR holds the back end until its second result is registered.
//    The back end's result register sets the rate: it refills in the cycle it is popped.
//  - Reset: A, X, Y clear, SP = 0xFD, status = 0x24, both stages empty.
//  - A stalled receiver holds the result register; the input register then
//    fills and full rises, so nothing is lost.
//
module cpu_8bit_execute_unit_top import c8eu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  din,
	output logic      empty,
	input  logic      pop,
	output out_item_t dout
);

	logic     f_valid, f_take;
	in_item_t f_item;

	// front end: holds one accepted request
	c8eu_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .din(din),
		.valid(f_valid), .item(f_item), .take(f_take)
	);

	// back end: register file, ALU and result register
	c8eu_back u_back (
		.clk(clk), .arst_n(arst_n), .valid(f_valid), .item(f_item),
		.take(f_take), .empty(empty), .pop(pop), .dout(dout)
	);

endmodule

// ===== sim/tb_cpu_8bit_execute_unit_top.sv =====
// Testbench for cpu_8bit_execute_unit_top: directed and random requests, with a
// scoreboard class holding its own model of the 6502-style register state.
// Depends on c8eu_pkg and the RTL of the execute unit.
`timescale 1ns / 100ps

module tb_cpu_8bit_execute_unit_top;
	import c8eu_pkg::*;

	localparam int  MAX_CYCLES = 400000;
	localparam int  N_RANDOM   = 1900;
	localparam logic [7:0] FL_C = 8'h01, FL_Z = 8'h02, FL_V = 8'h40, FL_N = 8'h80;

	// Scoreboard: predicts register state and keeps the queue of results due.
	class exec_scoreboard;
		logic [7:0] acc, xr, yr, sp, st;
		out_item_t due[$];
		int errors;

		function new();
			acc = 8'h00; xr = 8'h00; yr = 8'h00;
			sp = SP_RESET; st = FLAGS_RESET; errors = 0;
		endfunction

		function void upd_nz(logic [7:0] v);
			st = (st & ~(FL_N | FL_Z)) | (v & FL_N) | ((v == 8'h00) ? FL_Z : 8'h00);
		endfunction

		function void upd_c(logic c);
			st = (st & ~FL_C) | (c ? FL_C : 8'h00);
		endfunction

		function void add_carry(logic [7:0] m);
			logic [8:0] sum;
			logic [7:0] r;
			sum = {1'b0, acc} + {1'b0, m} + {8'h00, st[0]};
			r = sum[7:0];
			upd_c(sum[8]);
			st = (st & ~FL_V) | ((~(acc ^ m) & (acc ^ r) & 8'h80) != 0 ? FL_V : 8'h00);
			acc = r;
			upd_nz(r);
		endfunction

		function void cmp_reg(logic [7:0] rg, logic [7:0] m);
			upd_c(rg >= m);
			upd_nz(rg - m);
		endfunction

		function out_item_t snap(logic we, logic [15:0] wa, logic [7:0] wd,
				logic je, logic [15:0] jt, logic lst);
			out_item_t o;
			o.write_enable  = we;
			o.write_address = we ? wa : 16'h0;
			o.write_data    = we ? wd : 8'h0;
			o.jump_enable   = je;
			o.jump_target   = je ? jt : 16'h0;
			o.acc_out = acc; o.x_out = xr; o.y_out = yr;
			o.sp_out = sp;   o.flags_out = st;
			o.last = lst;
			return o;
		endfunction

		function void note_request(in_item_t rq);
			logic we, je, cin;
			logic [15:0] wa, jt, a1, a2;
			logic [7:0] wd, m, r, v;
			out_item_t o1;
			we = 0; je = 0; wa = 0; jt = 0; wd = 0; m = rq.operand;
			case (rq.op)
				OP_LDA: begin acc = m; upd_nz(m); end
				OP_LDX: begin xr = m; upd_nz(m); end
				OP_LDY: begin yr = m; upd_nz(m); end
				OP_STA: begin we = 1; wa = rq.address; wd = acc; end
				OP_STX: begin we = 1; wa = rq.address; wd = xr; end
				OP_STY: begin we = 1; wa = rq.address; wd = yr; end
				OP_TAX: begin xr = acc; upd_nz(xr); end
				OP_TAY: begin yr = acc; upd_nz(yr); end
				OP_TXA: begin acc = xr; upd_nz(acc); end
				OP_TYA: begin acc = yr; upd_nz(acc); end
				OP_TSX: begin xr = sp; upd_nz(xr); end
				OP_TXS: sp = xr;
				OP_PHA, OP_PHP: begin
					we = 1; wa = {STACK_PAGE, sp};
					wd = (rq.op == OP_PHA) ? acc : (st | 8'h30);
					sp = sp - 8'd1;
				end
				OP_PLA: begin sp = sp + 8'd1; acc = m; upd_nz(m); end
				OP_PLP: begin sp = sp + 8'd1; st = (m & 8'hCF) | 8'h20; end
				OP_AND: begin acc = acc & m; upd_nz(acc); end
				OP_EOR: begin acc = acc ^ m; upd_nz(acc); end
				OP_ORA: begin acc = acc | m; upd_nz(acc); end
				OP_BIT: st = (st & ~(FL_N | FL_V | FL_Z)) | (m & (FL_N | FL_V))
					| (((acc & m) == 8'h00) ? FL_Z : 8'h00);
				OP_ADC: add_carry(m);
				OP_SBC: add_carry(~m);
				OP_CMP: cmp_reg(acc, m);
				OP_CPX: cmp_reg(xr, m);
				OP_CPY: cmp_reg(yr, m);
				OP_INC, OP_DEC: begin
					r = (rq.op == OP_INC) ? m + 8'd1 : m - 8'd1;
					upd_nz(r); we = 1; wa = rq.address; wd = r;
				end
				OP_INX: begin xr = xr + 8'd1; upd_nz(xr); end
				OP_INY: begin yr = yr + 8'd1; upd_nz(yr); end
				OP_DEX: begin xr = xr - 8'd1; upd_nz(xr); end
				OP_DEY: begin yr = yr - 8'd1; upd_nz(yr); end
				OP_ASLA, OP_ASLM, OP_LSRA, OP_LSRM,
				OP_ROLA, OP_ROLM, OP_RORA, OP_RORM: begin
					v = rq.op[0] ? acc : m;   // odd codes work on A
					cin = st[0];
					if (rq.op <= OP_ASLM) begin upd_c(v[7]); r = v << 1; end
					else if (rq.op <= OP_LSRM) begin upd_c(v[0]); r = v >> 1; end
					else if (rq.op <= OP_ROLM) begin upd_c(v[7]); r = {v[6:0], cin}; end
					else begin upd_c(v[0]); r = {cin, v[7:1]}; end
					upd_nz(r);
					if (rq.op[0]) acc = r;
					else begin we = 1; wa = rq.address; wd = r; end
				end
				OP_JMP: begin je = 1; jt = rq.address; end
				OP_JSR: begin
					a1 = {STACK_PAGE, sp};
					a2 = {STACK_PAGE, sp - 8'd1};
					sp = sp - 8'd2;
					// both results show the state after the whole call
					due.push_back(snap(1, a1, rq.return_address[15:8], 0, 0, 0));
					due.push_back(snap(1, a2, rq.return_address[7:0], 1, rq.address, 1));
					return;
				end
				OP_RTS: begin
					sp = sp + 8'd2; je = 1;
					jt = {rq.operand_high, rq.operand} + 16'd1;
				end
				default: ;
			endcase
			o1 = snap(we, wa, wd, je, jt, 1);
			due.push_back(o1);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			exp_r = due.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected we=%0b wa=%h wd=%h je=%0b jt=%h a=%h x=%h y=%h sp=%h p=%h l=%0b / got we=%0b wa=%h wd=%h je=%0b jt=%h a=%h x=%h y=%h sp=%h p=%h l=%0b",
						exp_r.write_enable, exp_r.write_address, exp_r.write_data,
						exp_r.jump_enable, exp_r.jump_target, exp_r.acc_out, exp_r.x_out,
						exp_r.y_out, exp_r.sp_out, exp_r.flags_out, exp_r.last,
						got.write_enable, got.write_address, got.write_data,
						got.jump_enable, got.jump_target, got.acc_out, got.x_out,
						got.y_out, got.sp_out, got.flags_out, got.last);
			end
		endfunction
	endclass

	logic      clk, arst_n, push, pop, full, empty;
	in_item_t  din;
	out_item_t dout;
	exec_scoreboard sb;
	int cycles;
	bit stim_done;

	cpu_8bit_execute_unit_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .din(din),
		.empty(empty), .pop(pop), .dout(dout)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// gap length: mostly none or short, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one request from the falling edge and hold it until taken.
	task automatic send_request(in_item_t rq);
		din  <= rq;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_request(rq);
		@(negedge clk);
	endtask

	task automatic send_op(logic [5:0] op, logic [7:0] m, logic [7:0] mh = 8'h00,
			logic [15:0] ad = 16'h0000, logic [15:0] ra = 16'h0000);
		in_item_t rq;
		int g;
		rq.op = op; rq.operand = m; rq.operand_high = mh;
		rq.address = ad; rq.return_address = ra;
		send_request(rq);
		g = gap_len();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	function automatic in_item_t rand_request();
		in_item_t rq;
		rq.op = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(43, 63))
			: 6'($urandom_range(0, 42));
		rq.operand = 8'($urandom); rq.operand_high = 8'($urandom);
		rq.address = 16'($urandom); rq.return_address = 16'($urandom);
		if ($urandom_range(0, 5) == 0) rq.operand = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return rq;
	endfunction

	// Receiver: random stalls on pop, checking on every accepted result.
	initial begin
		int g;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g > 0) begin
				pop <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
				if (!empty) sb.check_result(dout);
			end
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("FAIL cpu_8bit_execute_unit_top");
			$finish;
		end
	end

	initial begin
		in_item_t rq;
		sb = new();
		cycles = 0;
		push = 1'b0;
		din = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: load extremes, flag corners, stack wrap, call and return.
		send_op(OP_LDA, 8'h00);
		send_op(OP_LDA, 8'h80);
		send_op(OP_LDX, 8'hFF);
		send_op(OP_LDY, 8'h7F);
		send_op(OP_ADC, 8'h7F);             // sum 0xFF, no carry or overflow
		send_op(OP_ADC, 8'h80);             // carry out
		send_op(OP_ADC, 8'h00);             // carry added once
		send_op(OP_SBC, 8'hFF);
		send_op(OP_CMP, 8'h00);
		send_op(OP_BIT, 8'hC0);
		send_op(OP_PHP, 8'h00);
		send_op(OP_PLP, 8'hFF);             // bits 4 and 5 of pulled byte ignored
		send_op(OP_PLP, 8'h00);
		send_op(OP_TYA, 8'h00);
		send_op(OP_ASLA, 8'h00);
		send_op(OP_RORM, 8'h01, 8'h00, 16'hFFFF);
		send_op(OP_LDX, 8'h00);
		send_op(OP_TXS, 8'h00);             // SP = 0 so pushes wrap
		send_op(OP_PHA, 8'h00);
		send_op(OP_JSR, 8'h00, 8'h00, 16'hFFFF, 16'hABCD);
		send_op(OP_RTS, 8'hFF, 8'hFF);      // target wraps to zero
		send_op(OP_PLA, 8'h00);
		send_op(OP_JMP, 8'h00, 8'h00, 16'h1234);
		send_op(6'd63, 8'hFF);              // highest unused code acts as NOP
		send_op(OP_NOP, 8'h00);

		// Sender holds off until every result is home.
		push <= 1'b0;
		while (sb.due.size() != 0) @(negedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			rq = rand_request();
			send_op(rq.op, rq.operand, rq.operand_high, rq.address, rq.return_address);
		end
		push <= 1'b0;

		while (sb.due.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.due.size() == 0)
			$display("PASS cpu_8bit_execute_unit_top");
		else
			$display("FAIL cpu_8bit_execute_unit_top");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/c8eu_pkg.sv
hw/rtl/c8eu_front.sv
hw/rtl/c8eu_back.sv
hw/rtl/cpu_8bit_execute_unit_top.sv
sim/tb_cpu_8bit_execute_unit_top.sv
